FILE: design/dtq_pkg.sv
// Shared types, codes and constants for the delimiter tokenizer with quotes.
package dtq_pkg;

   // Default number of delimiter compare lanes
   localparam int MAX_DELIMITERS_DEFAULT = 8;

   // Configuration port geometry
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 64;

   // Delimiter register geometry
   localparam int DELIM_CHARS_WIDTH = 64;
   localparam int DELIM_COUNT_WIDTH = 4;

   // Special bytes
   localparam logic [7:0] QUOTE_DOUBLE = 8'h22;
   localparam logic [7:0] QUOTE_SINGLE = 8'h27;
   localparam logic [7:0] END_CHAR     = 8'h00;

   // Result queue geometry
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_PTR_WIDTH   = $clog2(RSP_QUEUE_DEPTH);
   localparam int RSP_COUNT_WIDTH = $clog2(RSP_QUEUE_DEPTH + 1);

   // Register index, taken from the byte address
   typedef enum logic [1:0] {
      CSR_QUOTES_ENABLED  = 2'd0,
      CSR_DELIMITER_CHARS = 2'd1,
      CSR_DELIMITER_COUNT = 2'd2
   } csr_index_type;

   // Scanner state
   typedef enum logic [1:0] {
      SCAN_IDLE   = 2'd0,
      SCAN_WORD   = 2'd1,
      SCAN_QUOTED = 2'd2
   } scan_mode_type;

   // Result kind
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // Live configuration seen by the scanner
   typedef struct packed {
      logic                         quotes_enabled;
      logic [DELIM_CHARS_WIDTH-1:0] delimiter_chars;
      logic [DELIM_COUNT_WIDTH-1:0] delimiter_count;
   } cfg_type;

   // One result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] token_byte;
      logic       token_last;
   } rsp_item_type;

   // Up to two results caused by one request, in order
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } rsp_pair_type;

   // Result queue status
   typedef struct packed {
      logic [RSP_COUNT_WIDTH-1:0] count;
      logic                       not_empty;
      logic                       has_room;
   } queue_status_type;

   // Build a result item
   function automatic rsp_item_type make_item(kind_type kind, logic [7:0] token_byte,
                                              logic token_last);
      rsp_item_type item;
      item.kind       = kind;
      item.token_byte = token_byte;
      item.token_last = token_last;
      return item;
   endfunction

endpackage

FILE: design/delimiter_tokenizer_with_quotes_top.sv
// Top level of the delimiter tokenizer with quotes: register port, scanner and result queue.
//
// Splits a zero-terminated byte stream into tokens, one byte per request, at up to
// MAX_DELIMITERS configured delimiter bytes, with optional single- or double-quoted tokens.
// A request is taken in every cycle while the four-entry result queue has two free
// entries; its results can be taken from the next cycle on, one per cycle. Most bytes
// cause at most one result, so the block sustains one byte per clock; an end-of-string
// byte can cause two (the last token byte or empty marker, then the end marker), and
// the single result port sets the rate to one result per cycle. Token bytes leave one
// byte late so that the final byte of each token carries rsp_tlast. Configuration registers
// sit at byte addresses 0 (quotes_enabled), 8 (delimiter_chars) and 16 (delimiter_count)
// and are to be written only while no request is in progress (not enforced by the block).
module delimiter_tokenizer_with_quotes_top #(
   parameter int MAX_DELIMITERS = dtq_pkg::MAX_DELIMITERS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] ch
   // Result channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [7:0] token_byte
   output logic [1:0]                         rsp_tuser,   // [1:0] kind
   output logic                               rsp_tlast,   // token_last
   // Configuration port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dtq_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [dtq_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [dtq_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);

   logic                                  quotes_enabled_ff;
   logic [dtq_pkg::DELIM_CHARS_WIDTH-1:0] delimiter_chars_ff;
   logic [dtq_pkg::DELIM_COUNT_WIDTH-1:0] delimiter_count_ff;

   dtq_pkg::csr_index_type    csr_index;
   logic                      csr_write;
   dtq_pkg::cfg_type          cfg;
   dtq_pkg::rsp_pair_type     pair;
   dtq_pkg::rsp_item_type     head;
   dtq_pkg::queue_status_type queue_status;
   logic                      req_accept;
   logic                      rsp_accept;

   // Register decode: one register per 8-byte slot
   assign csr_index  = dtq_pkg::csr_index_type'(csr_paddr[4:3]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         quotes_enabled_ff  <= 1'b0;
         delimiter_chars_ff <= dtq_pkg::DELIM_CHARS_WIDTH'(64'd32);
         delimiter_count_ff <= dtq_pkg::DELIM_COUNT_WIDTH'(1);
      end else if (csr_write) begin
         case (csr_index)
            dtq_pkg::CSR_QUOTES_ENABLED:  quotes_enabled_ff  <= csr_pwdata[0];
            dtq_pkg::CSR_DELIMITER_CHARS: delimiter_chars_ff <= csr_pwdata;
            dtq_pkg::CSR_DELIMITER_COUNT:
               delimiter_count_ff <= csr_pwdata[dtq_pkg::DELIM_COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_index)
         dtq_pkg::CSR_QUOTES_ENABLED:
            csr_prdata = dtq_pkg::CSR_DATA_WIDTH'(quotes_enabled_ff);
         dtq_pkg::CSR_DELIMITER_CHARS:
            csr_prdata = delimiter_chars_ff;
         dtq_pkg::CSR_DELIMITER_COUNT:
            csr_prdata = dtq_pkg::CSR_DATA_WIDTH'(delimiter_count_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   assign cfg.quotes_enabled  = quotes_enabled_ff;
   assign cfg.delimiter_chars = delimiter_chars_ff;
   assign cfg.delimiter_count = delimiter_count_ff;

   // Handshakes
   assign req_tready = queue_status.has_room;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = queue_status.not_empty;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   dtq_scan #(
      .MAX_DELIMITERS(MAX_DELIMITERS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .accept(req_accept),
      .ch    (req_tdata),
      .cfg   (cfg),
      .pair  (pair)
   );

   dtq_rsp_queue u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_accept),
      .pair  (pair),
      .pop   (rsp_accept),
      .head  (head),
      .status(queue_status)
   );

   assign rsp_tdata = head.token_byte;
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.token_last;

`ifndef SYNTHESIS
   // An end-of-string request always leaves a result waiting
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tdata == dtq_pkg::END_CHAR) |=> rsp_tvalid)
      else $error("end of string left no result");

   // The queue never holds more than its depth
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_status.count <= dtq_pkg::RSP_COUNT_WIDTH'(dtq_pkg::RSP_QUEUE_DEPTH))
      else $error("result queue overflow");

   // Only the end of a string causes two results
   a_two_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (req_accept && pair.count == 2'd2) |-> (req_tdata == dtq_pkg::END_CHAR))
      else $error("two results from a byte other than end of string");

   // A request is never taken while the queue has fewer than two free entries
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      (queue_status.count > dtq_pkg::RSP_COUNT_WIDTH'(dtq_pkg::RSP_QUEUE_DEPTH - 2))
      |-> !req_accept)
      else $error("request accepted without room for its results");
`endif

endmodule

FILE: design/dtq_scan.sv
// Tokenizer scanner: delimiter and quote compares, scan state and result generation.
module dtq_scan #(
   parameter int MAX_DELIMITERS = dtq_pkg::MAX_DELIMITERS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            ch,
   input  dtq_pkg::cfg_type      cfg,
   output dtq_pkg::rsp_pair_type pair
);

   dtq_pkg::scan_mode_type mode_ff, mode_in;
   logic [7:0]             held_byte_ff, held_byte_in;
   logic                   held_valid_ff, held_valid_in;

   logic                   is_delim;
   logic                   is_quote;
   logic                   is_end;
   logic                   finish_valid;
   dtq_pkg::rsp_item_type  finish_item;
   dtq_pkg::rsp_item_type  held_item;
   dtq_pkg::rsp_item_type  end_item;

   // Compare against each delimiter lane in use
   always_comb begin
      is_delim = 1'b0;
      for (int i = 0; i < MAX_DELIMITERS; i++) begin
         if ((cfg.delimiter_count > dtq_pkg::DELIM_COUNT_WIDTH'(i)) &&
             (cfg.delimiter_chars[8*i +: 8] == ch)) begin
            is_delim = 1'b1;
         end
      end
   end

   assign is_quote = (ch == dtq_pkg::QUOTE_DOUBLE) || (ch == dtq_pkg::QUOTE_SINGLE);
   assign is_end   = (ch == dtq_pkg::END_CHAR);

   // Closing an open token: the held byte as last, or an empty quoted token
   assign finish_valid = held_valid_ff || (mode_ff == dtq_pkg::SCAN_QUOTED);
   assign finish_item  = held_valid_ff ?
                         dtq_pkg::make_item(dtq_pkg::KIND_BYTE, held_byte_ff, 1'b1) :
                         dtq_pkg::make_item(dtq_pkg::KIND_EMPTY, 8'h00, 1'b0);
   assign held_item    = dtq_pkg::make_item(dtq_pkg::KIND_BYTE, held_byte_ff, 1'b0);
   assign end_item     = dtq_pkg::make_item(dtq_pkg::KIND_END, 8'h00, 1'b0);

   // Next state
   always_comb begin
      mode_in       = mode_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (is_end) begin
         mode_in       = dtq_pkg::SCAN_IDLE;
         held_valid_in = 1'b0;
      end else begin
         case (mode_ff)
            dtq_pkg::SCAN_WORD: begin
               if (is_delim) begin
                  mode_in       = dtq_pkg::SCAN_IDLE;
                  held_valid_in = 1'b0;
               end else begin
                  held_byte_in  = ch;
                  held_valid_in = 1'b1;
               end
            end
            dtq_pkg::SCAN_QUOTED: begin
               if (is_quote) begin
                  mode_in       = dtq_pkg::SCAN_IDLE;
                  held_valid_in = 1'b0;
               end else begin
                  held_byte_in  = ch;
                  held_valid_in = 1'b1;
               end
            end
            default: begin
               held_valid_in = 1'b0;
               if (cfg.quotes_enabled && is_quote) begin
                  mode_in = dtq_pkg::SCAN_QUOTED;
               end else if (!is_delim) begin
                  mode_in       = dtq_pkg::SCAN_WORD;
                  held_byte_in  = ch;
                  held_valid_in = 1'b1;
               end else begin
                  mode_in = dtq_pkg::SCAN_IDLE;
               end
            end
         endcase
      end
   end

   // Results for the byte on the input
   always_comb begin
      pair.count = 2'd0;
      pair.item0 = end_item;
      pair.item1 = end_item;
      if (is_end) begin
         if ((mode_ff == dtq_pkg::SCAN_WORD || mode_ff == dtq_pkg::SCAN_QUOTED) &&
             finish_valid) begin
            pair.count = 2'd2;
            pair.item0 = finish_item;
         end else begin
            pair.count = 2'd1;
         end
      end else begin
         case (mode_ff)
            dtq_pkg::SCAN_WORD: begin
               if (is_delim) begin
                  pair.count = {1'b0, finish_valid};
                  pair.item0 = finish_item;
               end else begin
                  pair.count = {1'b0, held_valid_ff};
                  pair.item0 = held_item;
               end
            end
            dtq_pkg::SCAN_QUOTED: begin
               if (is_quote) begin
                  pair.count = {1'b0, finish_valid};
                  pair.item0 = finish_item;
               end else begin
                  pair.count = {1'b0, held_valid_ff};
                  pair.item0 = held_item;
               end
            end
            default: begin
               pair.count = 2'd0;
            end
         endcase
      end
   end

   // Advance the scan state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= dtq_pkg::SCAN_IDLE;
         held_valid_ff <= 1'b0;
      end else if (accept) begin
         mode_ff       <= mode_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // Held byte is payload and needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         held_byte_ff <= held_byte_in;
      end
   end

endmodule

FILE: design/dtq_rsp_queue.sv
// Small result queue: takes up to two results per cycle, hands out one per cycle on pop.
module dtq_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  dtq_pkg::rsp_pair_type     pair,
   input  logic                      pop,
   output dtq_pkg::rsp_item_type     head,
   output dtq_pkg::queue_status_type status
);

   localparam int DEPTH   = dtq_pkg::RSP_QUEUE_DEPTH;
   localparam int PTR_W   = dtq_pkg::RSP_PTR_WIDTH;
   localparam int COUNT_W = dtq_pkg::RSP_COUNT_WIDTH;

   dtq_pkg::rsp_item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [1:0]            push_n;

   assign push_n = push ? pair.count : 2'd0;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + COUNT_W'(push_n) - COUNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store new results in order at the tail
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         slot_ff[wr_ptr_ff] <= pair.item0;
      end
      if (push_n == 2'd2) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= pair.item1;
      end
   end

   assign head             = slot_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);
   // Room for the two results that one request may cause
   assign status.has_room  = (count_ff <= COUNT_W'(DEPTH - 2));

endmodule

FILE: sim/dtq_token_ledger_pkg.sv
// Token ledger: predicts the tokenizer results for each accepted request and checks them.
`timescale 1ns / 100ps

package dtq_token_ledger_pkg;

   import dtq_pkg::*;

   class token_ledger;

      // Live copy of the registers
      bit            quoting;
      logic [63:0]   delim_bytes;
      logic [3:0]    delim_count;

      // Scanner state
      scan_mode_type mode;
      logic [7:0]    held_byte;
      bit            held_valid;

      rsp_item_type  awaited_results[$];
      int            mismatches;

      function new();
         quoting     = 1'b0;
         delim_bytes = 64'd32;
         delim_count = 4'd1;
         mode        = SCAN_IDLE;
         held_byte   = 8'h00;
         held_valid  = 1'b0;
         mismatches  = 0;
      endfunction

      // Mirror a register write, masked to the register width
      function void set_register(csr_index_type idx, logic [63:0] value);
         case (idx)
            CSR_QUOTES_ENABLED:  quoting = value[0];
            CSR_DELIMITER_CHARS: delim_bytes = value;
            CSR_DELIMITER_COUNT: delim_count = value[3:0];
            default: ;
         endcase
      endfunction

      function bit is_quote(logic [7:0] ch);
         return ch == QUOTE_DOUBLE || ch == QUOTE_SINGLE;
      endfunction

      // Compare against the active lanes; counts above the lane total saturate
      function bit is_delimiter(logic [7:0] ch);
         int lanes;
         lanes = (delim_count > MAX_DELIMITERS_DEFAULT) ? MAX_DELIMITERS_DEFAULT
                                                        : int'(delim_count);
         for (int i = 0; i < lanes; i++) begin
            if (delim_bytes[8*i +: 8] == ch) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void emit(kind_type kind, logic [7:0] token_byte, logic token_last);
         rsp_item_type item;
         item.kind       = kind;
         item.token_byte = token_byte;
         item.token_last = token_last;
         awaited_results.push_back(item);
      endfunction

      // Finish the open token: held byte goes out as last, or an empty quoted marker
      function void close_token();
         if (held_valid) begin
            emit(KIND_BYTE, held_byte, 1'b1);
         end else if (mode == SCAN_QUOTED) begin
            emit(KIND_EMPTY, 8'h00, 1'b0);
         end
         held_valid = 1'b0;
         held_byte  = 8'h00;
         mode       = SCAN_IDLE;
      endfunction

      // Release the previous held byte and hold the new one
      function void append_byte(logic [7:0] ch);
         if (held_valid) emit(KIND_BYTE, held_byte, 1'b0);
         held_byte  = ch;
         held_valid = 1'b1;
      endfunction

      // Advance the scanner by one accepted request
      function void note_request(logic [7:0] ch);
         if (ch == END_CHAR) begin
            if (mode == SCAN_WORD || mode == SCAN_QUOTED) close_token();
            held_valid = 1'b0;
            held_byte  = 8'h00;
            mode       = SCAN_IDLE;
            emit(KIND_END, 8'h00, 1'b0);
         end else begin
            case (mode)
               SCAN_WORD: begin
                  if (is_delimiter(ch)) close_token();
                  else append_byte(ch);
               end
               SCAN_QUOTED: begin
                  if (is_quote(ch)) close_token();
                  else append_byte(ch);
               end
               default: begin
                  held_valid = 1'b0;
                  held_byte  = 8'h00;
                  // a quote wins over a delimiter of the same value
                  if (quoting && is_quote(ch)) begin
                     mode = SCAN_QUOTED;
                  end else if (!is_delimiter(ch)) begin
                     mode = SCAN_WORD;
                     append_byte(ch);
                  end else begin
                     mode = SCAN_IDLE;
                  end
               end
            endcase
         end
      endfunction

      // Compare one accepted result with the oldest awaited one
      function void check_result(logic [1:0] kind, logic [7:0] token_byte, logic token_last);
         rsp_item_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual kind %0d byte 0x%02h last %0d",
                     $time, kind, token_byte, token_last);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         if (want.kind !== kind) begin
            $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, kind);
            mismatches++;
         end
         if (want.token_byte !== token_byte) begin
            $display("%0t: token byte mismatch: expected 0x%02h, actual 0x%02h",
                     $time, want.token_byte, token_byte);
            mismatches++;
         end
         if (want.token_last !== token_last) begin
            $display("%0t: token last mismatch: expected %0d, actual %0d",
                     $time, want.token_last, token_last);
            mismatches++;
         end
      endfunction

      function int pending();
         return awaited_results.size();
      endfunction

   endclass

endpackage

FILE: sim/delimiter_tokenizer_with_quotes_top_tb.sv
// Testbench for the delimiter tokenizer with quotes: directed and random text streams.
`timescale 1ns / 100ps

module delimiter_tokenizer_with_quotes_top_tb;

   import dtq_pkg::*;
   import dtq_token_ledger_pkg::*;

   localparam int          RANDOM_PHASES  = 7;
   localparam int          PHASE_BYTES    = 250;
   localparam int          DRAIN_CYCLES   = 4;
   localparam int          STALL_LIMIT    = 500;
   localparam logic [63:0] PUNCT_DELIMS   = 64'h2C3B_090A_7C3A_2E20;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = 8'h00;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;
   logic [1:0]                rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   token_ledger               ledger;
   logic [7:0]                byte_stream[$];
   bit                        calm = 1'b0;
   int                        idle_cycles = 0;
   int                        send_stretch = 0;
   bit                        send_quiet = 1'b0;

   delimiter_tokenizer_with_quotes_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] ch
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [7:0] token_byte
      .rsp_tuser   (rsp_tuser),   // [1:0] kind
      .rsp_tlast   (rsp_tlast),   // token_last
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Check every result taken from the block
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         ledger.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
      end
   end

   // Stall the result side in random bursts, with quiet stretches in between
   initial begin
      int stall_left;
      int stretch_left;
      bit quiet;
      stall_left   = 0;
      stretch_left = 0;
      quiet        = 1'b0;
      forever begin
         @(posedge clock);
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 80);
            quiet        = ($urandom_range(0, 2) == 0);
         end
         stretch_left--;
         if (stall_left == 0 && !calm && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8);
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Drop the run when nothing has moved for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, idle_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // One register access: setup cycle, then access cycle until pready
   task automatic csr_access(input bit write, input csr_index_type idx,
                             input logic [63:0] wdata, output logic [63:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_WIDTH'(8 * int'(idx));
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
   endtask

   // Write all three registers (junk above the narrow fields) and read each one back
   task automatic apply_config(input bit quoting, input logic [63:0] chars,
                               input logic [3:0] count);
      logic [63:0]   wr[3];
      logic [63:0]   keep[3];
      logic [63:0]   readback;
      csr_index_type idx;
      wr[0]       = {$urandom, $urandom};
      wr[0][0]    = quoting;
      wr[1]       = chars;
      wr[2]       = {$urandom, $urandom};
      wr[2][3:0]  = count;
      keep[0]     = 64'h1;
      keep[1]     = '1;
      keep[2]     = 64'hF;
      for (int i = 0; i < 3; i++) begin
         idx = csr_index_type'(i);
         csr_access(1'b1, idx, wr[i], readback);
         ledger.set_register(idx, wr[i]);
         csr_access(1'b0, idx, 64'd0, readback);
         if (readback !== (wr[i] & keep[i])) begin
            $display("%0t: register %0d readback: expected 0x%016h, actual 0x%016h",
                     $time, i, wr[i] & keep[i], readback);
            ledger.mismatches++;
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Hold until every awaited result has come, then let the pipeline settle
   task automatic wait_quiet();
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Send the queued bytes, one request each, with random gaps
   task automatic send_text();
      logic [7:0] ch;
      int         gap;
      while (byte_stream.size() != 0) begin
         ch = byte_stream.pop_front();
         if (send_stretch == 0) begin
            send_stretch = $urandom_range(10, 60);
            send_quiet   = ($urandom_range(0, 2) == 0);
         end
         send_stretch--;
         if (!calm && !send_quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= ch;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         ledger.note_request(ch);
      end
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_quote();
      return $urandom_range(0, 1) ? QUOTE_DOUBLE : QUOTE_SINGLE;
   endfunction

   // One of the active delimiter bytes; a space where none are active or the pick is the end byte
   function automatic logic [7:0] pick_delimiter();
      int         lanes;
      logic [7:0] ch;
      lanes = (ledger.delim_count > 8) ? 8 : int'(ledger.delim_count);
      if (lanes == 0) return 8'h20;
      ch = ledger.delim_bytes[8 * $urandom_range(0, lanes - 1) +: 8];
      return (ch == END_CHAR) ? 8'h20 : ch;
   endfunction

   // A non-delimiter byte; no quote where it would open or close a quoted token
   function automatic logic [7:0] pick_word_byte(input bit no_quote);
      logic [7:0] ch;
      ch = 8'h61;
      for (int tries = 0; tries < 16; tries++) begin
         ch = $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                   : 8'($urandom_range(1, 255));
         if (!ledger.is_delimiter(ch) && !(no_quote && ledger.is_quote(ch))) break;
      end
      return ch;
   endfunction

   // Build strings of words, quoted tokens and delimiter runs, with some noise
   task automatic build_text(input int target);
      int segments;
      int len;
      int pick;
      while (byte_stream.size() < target) begin
         if ($urandom_range(0, 9) == 0) byte_stream.push_back(pick_delimiter());
         segments = $urandom_range(1, 6);
         for (int s = 0; s < segments; s++) begin
            if (s > 0) begin
               repeat ($urandom_range(1, 3)) byte_stream.push_back(pick_delimiter());
            end
            pick = $urandom_range(0, 99);
            if (pick < 50 || (pick < 85 && !ledger.quoting)) begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++) begin
                  byte_stream.push_back(pick_word_byte(i == 0 && ledger.quoting));
               end
            end else if (pick < 85) begin
               byte_stream.push_back(pick_quote());
               len = $urandom_range(0, 5);
               for (int i = 0; i < len; i++) begin
                  byte_stream.push_back($urandom_range(0, 3) == 0 ? pick_delimiter()
                                                                  : pick_word_byte(1'b1));
               end
               // leave some quoted tokens open
               if ($urandom_range(0, 7) != 0) byte_stream.push_back(pick_quote());
            end else begin
               byte_stream.push_back(8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 15) != 0) byte_stream.push_back(END_CHAR);
      end
   endtask

   initial begin
      bit          quoting;
      logic [63:0] chars;
      logic [3:0]  count;
      ledger = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: space only, quotes are plain word bytes, end in idle
      byte_stream = '{8'h61, 8'h20, 8'h27, 8'hFF, 8'h20, 8'h00, 8'h00};
      send_text();
      wait_quiet();

      // Quoting on, single quote also a delimiter: empty, kept delimiters,
      // unterminated tokens, quote inside a word, and a token left open
      apply_config(1'b1, 64'h0000_0000_0027_2C20, 4'd3);
      byte_stream = '{8'h27, 8'h27, 8'h22, 8'h61, 8'h2C, 8'h62, 8'h27, 8'h22, 8'h00,
                      8'h27, 8'h7A, 8'h00, 8'h77, 8'h22, 8'h2C, 8'h27};
      send_text();
      wait_quiet();

      // Quoting off while a quoted token is open: it still closes on a quote
      apply_config(1'b0, 64'h0000_0000_0027_2C20, 4'd3);
      byte_stream = '{8'h71, 8'h22, 8'h00};
      send_text();
      wait_quiet();

      // Random text under a range of settings; the last phase runs without idling
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin quoting = 1'b1; chars = PUNCT_DELIMS;          count = 4'd8; end
            1: begin quoting = 1'b0; chars = '1;                    count = 4'd15; end
            2: begin quoting = 1'b1; chars = '0;                    count = 4'd0; end
            3: begin
               quoting = 1'b1;
               chars   = PUNCT_DELIMS ^ ({$urandom, $urandom} & 64'h00FF_00FF_00FF_00FF);
               count   = 4'($urandom_range(1, 8));
            end
            4: begin
               quoting = 1'b0;
               chars   = {$urandom, $urandom};
               count   = 4'($urandom_range(0, 15));
            end
            5: begin quoting = 1'b1; chars = 64'h0000_0000_2227_2C20; count = 4'd4; end
            default: begin quoting = 1'b1; chars = PUNCT_DELIMS; count = 4'd3; end
         endcase
         apply_config(quoting, chars, count);
         if (p == RANDOM_PHASES - 1) calm = 1'b1;
         build_text(PHASE_BYTES);
         send_text();
         wait_quiet();
      end

      repeat (16) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
